// ===== rtl/core/stbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and codes for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // input item kind, carried on in_tuser
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_DONE  = 4'b1000
  } stbs_state_t;

  // controller to datapath
  typedef struct packed {
    logic wr_en;     // store one table entry
    logic start;     // load key and initial range
    logic probe_rd;  // read the middle entry of the range
    logic step;      // narrow the range after a miss on the probe
    logic set_hit;   // record a match at the probed position
    logic set_miss;  // record key not found
    logic push;      // move the result into the output register
  } stbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic range_empty;
    logic hit;
    logic out_free;
  } stbs_status_t;

endpackage : stbs_pkg
`default_nettype wire

// ===== rtl/core/sorted_table_binary_search_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Binary search over a configurable-length table of signed 32-bit words.
// ----------------------------------------------------------------------------
// A write item (in_tuser = 0) stores one word into the table and gives no
// result; positions at or above TABLE_DEPTH are dropped. A search item
// (in_tuser = 1) looks up its key among the first cfg_wr_data entries
// (saturated to TABLE_DEPTH) and returns one result: found on out_tuser and
// the matching position on out_tdata, or position 0 when not found. Each probe
// reads the middle entry of the range from the table memory, which has a
// registered read port, and then compares it with the key and narrows the
// range; a search that misses ends when the range is empty. A 64-entry table
// needs up to seven probes, and the next item is taken once the result sits
// in the output register. The table is not cleared by reset: every entry a
// search can reach must be written first.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,    // entries_in_use
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [71:0] in_tdata,       // entry_index[5:0], entry_value[37:6],
                                           // search_key[69:38], zero pad
  input  wire logic        in_tuser,       // mode
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [7:0]  out_tdata,      // position[5:0], zero pad
  output      logic        out_tuser       // found
);

  stbs_cmd_t    cmd;
  stbs_status_t status;
  logic [5:0]   out_position;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_entry_index (in_tdata[5:0]),
    .in_entry_value (in_tdata[37:6]),
    .in_search_key  (in_tdata[69:38]),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_found      (out_tuser),
    .out_position   (out_position)
  );

  assign out_tdata = {2'b00, out_position};

endmodule : sorted_table_binary_search_top
`default_nettype wire

// ===== rtl/core/stbs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for table writes and the probe / compare loop of a search.
// ----------------------------------------------------------------------------
module stbs_ctrl
  import stbs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_mode,
  output      logic         in_tready,
  input  wire stbs_status_t status,
  output      stbs_cmd_t    cmd
);

  stbs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_mode == MODE_SEARCH) begin
            cmd.start = 1'b1;
            state_nxt = ST_PROBE;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status.range_empty) begin
          cmd.set_miss = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.probe_rd = 1'b1;
          state_nxt    = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status.hit) begin
          cmd.set_hit = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_PROBE;
        end
      end
      ST_DONE: begin
        // wait for the output register to have room
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule : stbs_ctrl
`default_nettype wire

// ===== rtl/core/stbs_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_datapath
// Table memory, search range registers, compare and output register.
// ----------------------------------------------------------------------------
module stbs_datapath
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire stbs_cmd_t                cmd,
  output      stbs_status_t             status,
  input  wire logic                     cfg_wr_en,
  input  wire logic [6:0]               cfg_wr_data,
  input  wire logic [5:0]               in_entry_index,
  input  wire logic signed [DATA_W-1:0] in_entry_value,
  input  wire logic signed [DATA_W-1:0] in_search_key,
  input  wire logic                     out_tready,
  output      logic                     out_tvalid,
  output      logic                     out_found,
  output      logic [5:0]               out_position
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];

  logic [6:0]               entries_r;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         lo_r, hi_r, mid;
  logic [IDX_W-1:0]         mid_r;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] rdata_r;
  logic                     key_above;
  logic                     res_found_r;
  logic [IDX_W-1:0]         res_pos_r;
  logic                     out_tvalid_r;
  logic                     out_found_r;
  logic [5:0]               out_position_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  // counts above the table depth saturate
  assign count = (32'(entries_r) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(entries_r);

  // probe at low + (high - low) / 2 over the inclusive range, high = hi_r - 1
  assign mid = lo_r + ((hi_r - lo_r - CNT_W'(1)) >> 1);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && (32'(in_entry_index) < TABLE_DEPTH)) begin
      table_mem[IDX_W'(in_entry_index)] <= in_entry_value;
    end
    if (cmd.probe_rd) begin
      rdata_r <= table_mem[mid[IDX_W-1:0]];
    end
  end

  assign key_above = key_r > rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_search_key;
      lo_r  <= '0;
      hi_r  <= count;
    end else if (cmd.step) begin
      if (key_above) begin
        lo_r <= CNT_W'(mid_r) + CNT_W'(1);
      end else begin
        hi_r <= CNT_W'(mid_r);
      end
    end
    if (cmd.probe_rd) begin
      mid_r <= mid[IDX_W-1:0];
    end
    if (cmd.set_hit) begin
      res_found_r <= 1'b1;
      res_pos_r   <= mid_r;
    end else if (cmd.set_miss) begin
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.push) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_found_r    <= res_found_r;
      out_position_r <= 6'(res_pos_r);
    end
  end

  assign status.range_empty = (lo_r >= hi_r);
  assign status.hit         = (rdata_r == key_r);
  assign status.out_free    = !out_tvalid_r || out_tready;

  assign out_tvalid   = out_tvalid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule : stbs_datapath
`default_nettype wire
